@@ design/oaht_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared constants, codes and controller/datapath interface types for the
// open addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

    // default configuration
    localparam int TABLE_SLOTS_DEF = 64;
    localparam int KEY_BITS_DEF    = 16;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int KEY_IN_W = 16;
    localparam int VALUE_W  = 16;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int PROBES_W = 7;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OTHER     = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic                load;        // capture item
        logic                div_step;    // reciprocal multiply for both quotients
        logic                setup;       // load home slot and probe step
        logic                step_fix;    // reduce probe step below table size
        logic                issue;       // read home slot
        logic                probe;       // advance to next slot on the path
        logic                write_entry; // store item at current slot
        logic                clr_step;    // clear one slot
        logic                res_load;    // capture result
        logic [STATUS_W-1:0] res_status;
        logic                out_load;    // move result to output register
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_insert;
        logic is_lookup;
        logic is_clear;
        logic key_zero;
        logic step_ge_n;
        logic hit_key;
        logic hit_empty;
        logic n_last;
        logic clr_last;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

@@ design/open_addressing_hash_table_top.sv @@
`default_nettype none
// Insert/lookup: a reciprocal multiply gives both remainders, then the probe loop
// does one slot memory read a cycle. Tables of ten slots or fewer may pass the step
// fix state, which reduces the probe step below the table size.
// Clear empties every slot; a zero key or unknown command goes straight to the result.
// One item at a time; the next item is taken while the result waits at the output.
// Reset: a clearing pass over every slot, s_tready low.
// ----------------------------------------------------------------------------
// open_addressing_hash_table_top
// Open addressing hash table with home slot key mod size and probe step
// (key mod ten) + 1, command items in, one result item out per command.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_top #(
    parameter int TABLE_SLOTS = oaht_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_BITS    = oaht_pkg::KEY_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [31:0]                   s_tdata,   // key[15:0], value[31:16]
    input  wire logic [oaht_pkg::CMD_W-1:0]    s_tuser,   // cmd[1:0]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [31:0]                        m_tdata,   // slot[5:0], probes[12:6],
                                                          // found_value[28:13]
    output logic [oaht_pkg::STATUS_W-1:0]      m_tuser    // status[2:0]
);

    oaht_pkg::dp_cmd_t  dp_cmd;
    oaht_pkg::dp_stat_t dp_stat;

    // sequencer
    oaht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd_o    (dp_cmd),
        .stat_i   (dp_stat)
    );

    // memories and arithmetic
    oaht_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BITS    (KEY_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_i    (dp_cmd),
        .stat_o   (dp_stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

@@ design/oaht_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_datapath
// Slot memories, remainder unit, probe position and counters, result and
// output registers of the hash table.
// ----------------------------------------------------------------------------
module oaht_datapath #(
    parameter int TABLE_SLOTS = oaht_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_BITS    = oaht_pkg::KEY_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire oaht_pkg::dp_cmd_t             cmd_i,
    output oaht_pkg::dp_stat_t                 stat_o,
    input  wire logic [31:0]                   s_tdata,
    input  wire logic [oaht_pkg::CMD_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [31:0]                        m_tdata,
    output logic [oaht_pkg::STATUS_W-1:0]      m_tuser
);

    localparam int SW   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int PW   = ((SW > 4) ? SW : 4) + 1;
    localparam int NW   = $clog2(TABLE_SLOTS + 1);
    localparam int KW   = oaht_pkg::KEY_IN_W;
    localparam int MW   = KW + 2;
    localparam int PRW  = KW + MW;
    localparam int NSH  = KW + SW;
    localparam int TSH  = KW + 4;
    localparam int STEP_MOD = 10;

    // rounded-up reciprocals, exact for every key below 2**KW
    localparam longint NMUL = ((longint'(1) << NSH) + longint'(TABLE_SLOTS - 1))
                              / longint'(TABLE_SLOTS);
    localparam longint TMUL = ((longint'(1) << TSH) + longint'(STEP_MOD - 1))
                              / longint'(STEP_MOD);

    localparam logic [MW-1:0] NMUL_C = MW'(NMUL);
    localparam logic [MW-1:0] TMUL_C = MW'(TMUL);
    localparam logic [KW-1:0] KN_C   = KW'(TABLE_SLOTS);
    localparam logic [KW-1:0] KT_C   = KW'(STEP_MOD);
    localparam logic [PW-1:0] NP  = PW'(TABLE_SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SLOTS - 1);

    // slot memories
    logic [KEY_BITS-1:0]         key_mem  [TABLE_SLOTS];
    logic [oaht_pkg::VALUE_W-1:0] val_mem [TABLE_SLOTS];
    logic [oaht_pkg::PROBES_W-1:0] plen_mem [TABLE_SLOTS];

    logic [oaht_pkg::CMD_W-1:0]   cmd_reg;
    logic [KEY_BITS-1:0]          key_reg;
    logic [oaht_pkg::VALUE_W-1:0] val_reg;
    logic [KW-1:0]                qn_reg;
    logic [KW-1:0]                qt_reg;
    logic [SW-1:0]                pos_reg, pos_next;
    logic [3:0]                   step_reg;
    logic [NW-1:0]                n_reg;
    logic [SW-1:0]                clr_idx_reg;
    logic [KEY_BITS-1:0]          rd_key_q;
    logic [oaht_pkg::VALUE_W-1:0] rd_val_q;

    logic [oaht_pkg::STATUS_W-1:0] res_status_reg;
    logic [oaht_pkg::SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [oaht_pkg::PROBES_W-1:0] res_probes_reg, res_probes_next;
    logic [oaht_pkg::VALUE_W-1:0]  res_val_reg, res_val_next;

    logic                          m_tvalid_reg;
    logic [31:0]                   m_tdata_reg;
    logic [oaht_pkg::STATUS_W-1:0] m_tuser_reg;

    logic [KW-1:0]  key_lo;
    logic [PRW-1:0] prod_n;
    logic [PRW-1:0] prod_t;
    logic [KW-1:0]  rem_n;
    logic [KW-1:0]  rem_t;
    logic [PW-1:0]  sum;
    logic [SW-1:0]  rd_addr;

    logic                          wr_en;
    logic [SW-1:0]                 wr_addr;
    logic [KEY_BITS-1:0]           wr_key;
    logic [oaht_pkg::VALUE_W-1:0]  wr_val;
    logic [oaht_pkg::PROBES_W-1:0] wr_plen;

    // key mod table size and key mod ten by reciprocal multiplication
    always_comb begin
        key_lo = KW'(key_reg);
        prod_n = PRW'(key_lo) * PRW'(NMUL_C);
        prod_t = PRW'(key_lo) * PRW'(TMUL_C);
        rem_n  = key_lo - KW'(qn_reg * KN_C);
        rem_t  = key_lo - KW'(qt_reg * KT_C);
    end

    // next slot on the probe path, wrapping at table size
    always_comb begin
        sum = PW'(pos_reg) + PW'(step_reg);
        if (sum >= NP) begin
            pos_next = SW'(sum - NP);
        end else begin
            pos_next = SW'(sum);
        end
    end

    assign rd_addr = cmd_i.issue ? pos_reg : pos_next;

    // write port: clearing pass or insert
    always_comb begin
        wr_en   = cmd_i.clr_step | cmd_i.write_entry;
        wr_addr = cmd_i.clr_step ? clr_idx_reg : pos_reg;
        wr_key  = cmd_i.clr_step ? '0 : key_reg;
        wr_val  = cmd_i.clr_step ? '0 : val_reg;
        wr_plen = cmd_i.clr_step ? '0 : oaht_pkg::PROBES_W'(n_reg);
    end

    // slot memories, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr]  <= wr_key;
            val_mem[wr_addr]  <= wr_val;
            plen_mem[wr_addr] <= wr_plen;
        end
        rd_key_q <= key_mem[rd_addr];
        rd_val_q <= val_mem[rd_addr];
    end

    // item capture, quotients, probe state
    always_ff @(posedge aclk) begin
        if (cmd_i.load) begin
            cmd_reg <= s_tuser;
            key_reg <= KEY_BITS'(s_tdata[15:0]);
            val_reg <= s_tdata[31:16];
            n_reg   <= NW'(1);
        end else if (cmd_i.div_step) begin
            qn_reg <= KW'(prod_n >> NSH);
            qt_reg <= KW'(prod_t >> TSH);
        end
        if (cmd_i.setup) begin
            pos_reg  <= SW'(rem_n);
            step_reg <= 4'(rem_t) + 4'd1;
        end else if (cmd_i.step_fix) begin
            step_reg <= 4'(PW'(step_reg) - NP);
        end else if (cmd_i.probe) begin
            pos_reg <= pos_next;
            n_reg   <= n_reg + NW'(1);
        end
    end

    // clearing index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
        end else begin
            if (cmd_i.clr_step) begin
                clr_idx_reg <= (clr_idx_reg == LAST_SLOT) ? '0 : clr_idx_reg + SW'(1);
            end
        end
    end

    // result fields follow the status
    always_comb begin
        res_slot_next   = '0;
        res_probes_next = '0;
        res_val_next    = '0;
        unique case (cmd_i.res_status) inside
            oaht_pkg::ST_INSERTED: begin
                res_slot_next   = oaht_pkg::SLOT_W'(pos_reg);
                res_probes_next = oaht_pkg::PROBES_W'(n_reg);
            end
            oaht_pkg::ST_FOUND: begin
                res_slot_next   = oaht_pkg::SLOT_W'(pos_reg);
                res_probes_next = oaht_pkg::PROBES_W'(n_reg);
                res_val_next    = rd_val_q;
            end
            oaht_pkg::ST_NOT_FOUND, oaht_pkg::ST_FULL: begin
                res_probes_next = oaht_pkg::PROBES_W'(n_reg);
            end
            default: begin
                res_probes_next = '0;
            end
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd_i.res_load) begin
            res_status_reg <= cmd_i.res_status;
            res_slot_reg   <= res_slot_next;
            res_probes_reg <= res_probes_next;
            res_val_reg    <= res_val_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd_i.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.out_load) begin
            m_tdata_reg <= {3'b000, res_val_reg, res_probes_reg, res_slot_reg};
            m_tuser_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // status to controller
    always_comb begin
        stat_o.is_insert = (cmd_reg == oaht_pkg::CMD_INSERT);
        stat_o.is_lookup = (cmd_reg == oaht_pkg::CMD_LOOKUP);
        stat_o.is_clear  = (cmd_reg == oaht_pkg::CMD_CLEAR);
        stat_o.key_zero  = (key_reg == '0);
        stat_o.step_ge_n = (PW'(step_reg) >= NP);
        stat_o.hit_key   = (rd_key_q == key_reg);
        stat_o.hit_empty = (rd_key_q == '0);
        stat_o.n_last    = (n_reg == NW'(TABLE_SLOTS));
        stat_o.clr_last  = (clr_idx_reg == LAST_SLOT);
        stat_o.out_free  = !m_tvalid_reg || m_tready;
    end

endmodule
`default_nettype wire

@@ design/oaht_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// oaht_ctrl
// Sequencer of the hash table: clearing pass, remainder steps, probe loop
// and result hand-off.
// ----------------------------------------------------------------------------
module oaht_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output oaht_pkg::dp_cmd_t       cmd_o,
    input  wire oaht_pkg::dp_stat_t stat_i
);

    typedef enum logic [3:0] {
        S_INIT_CLR,
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_SETUP,
        S_FIX,
        S_CHECK,
        S_CLR,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // next state and datapath commands
    always_comb begin
        state_next       = state_reg;
        cmd_o            = '0;
        cmd_o.res_status = oaht_pkg::ST_OTHER;
        unique case (state_reg)
            S_INIT_CLR: begin
                cmd_o.clr_step = 1'b1;
                if (stat_i.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_o.load = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat_i.is_clear) begin
                    state_next = S_CLR;
                end else if ((!stat_i.is_insert && !stat_i.is_lookup) || stat_i.key_zero) begin
                    cmd_o.res_load = 1'b1;
                    state_next     = S_OUT;
                end else begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd_o.div_step = 1'b1;
                state_next     = S_SETUP;
            end
            S_SETUP: begin
                cmd_o.setup = 1'b1;
                state_next  = S_FIX;
            end
            S_FIX: begin
                if (stat_i.step_ge_n) begin
                    cmd_o.step_fix = 1'b1;
                end else begin
                    cmd_o.issue = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat_i.is_insert) begin
                    if (stat_i.hit_empty) begin
                        cmd_o.write_entry = 1'b1;
                        cmd_o.res_load    = 1'b1;
                        cmd_o.res_status  = oaht_pkg::ST_INSERTED;
                        state_next        = S_OUT;
                    end else if (stat_i.n_last) begin
                        cmd_o.res_load   = 1'b1;
                        cmd_o.res_status = oaht_pkg::ST_FULL;
                        state_next       = S_OUT;
                    end else begin
                        cmd_o.probe = 1'b1;
                    end
                end else begin
                    if (stat_i.hit_key) begin
                        cmd_o.res_load   = 1'b1;
                        cmd_o.res_status = oaht_pkg::ST_FOUND;
                        state_next       = S_OUT;
                    end else if (stat_i.hit_empty || stat_i.n_last) begin
                        cmd_o.res_load   = 1'b1;
                        cmd_o.res_status = oaht_pkg::ST_NOT_FOUND;
                        state_next       = S_OUT;
                    end else begin
                        cmd_o.probe = 1'b1;
                    end
                end
            end
            S_CLR: begin
                cmd_o.clr_step = 1'b1;
                if (stat_i.clr_last) begin
                    cmd_o.res_load = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_OUT: begin
                if (stat_i.out_free) begin
                    cmd_o.out_load = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
